### rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants of the keyframe track sampler.
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int KTS_MAX_FRAMES = 64;
    localparam int KTS_CNT_W      = 7;
    localparam int KTS_NVAL       = 6;
    localparam int KTS_ANGLE_IDX  = 5;
    localparam int KTS_FIX_PI     = 205887;
    localparam int KTS_FIX_TWO_PI = 411774;
    localparam logic [15:0] KTS_TOL_RESET = 16'd66;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_SAMPLE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // one stored keyframe: time and six q16.16 values
    typedef struct packed {
        logic [23:0]      tm;
        logic [5:0][31:0] val;
    } t_frame;

    typedef struct packed {
        logic [5:0][31:0] val;
        logic [23:0]      duration;
        t_status          status;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_CHK,
        S_DEL_END,
        S_INS_RD,
        S_INS_CHK,
        S_INS_PUT,
        S_SA_RD,
        S_SA_CHK,
        S_SB_RD,
        S_SB_CHK,
        S_SC_RD,
        S_SC_CHK,
        S_DIV,
        S_ROT,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

endpackage

### rtl/kts_item_if.sv
// ----------------------------------------------------------------------------
// kts_item_if
// Input channel: one operation word with keyframe payload.
// ----------------------------------------------------------------------------
interface kts_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [23:0]        key_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] bone_length;
    logic signed [31:0] angle;

    modport source (
        output valid, operation, key_time, pos_x, pos_y, scale_x, scale_y,
               bone_length, angle,
        input  ready
    );
    modport sink (
        input  valid, operation, key_time, pos_x, pos_y, scale_x, scale_y,
               bone_length, angle,
        output ready
    );
endinterface

### rtl/kts_result_if.sv
// ----------------------------------------------------------------------------
// kts_result_if
// Output channel: one result word per operation.
// ----------------------------------------------------------------------------
interface kts_result_if #(
    parameter int CNT_W = kts_pkg::KTS_CNT_W
);
    logic               valid;
    logic               ready;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_scale_x;
    logic signed [31:0] out_scale_y;
    logic signed [31:0] out_length;
    logic signed [31:0] out_angle;
    logic [CNT_W-1:0]   stored_count;
    logic [23:0]        track_duration;
    logic [1:0]         status;

    modport source (
        output valid, out_pos_x, out_pos_y, out_scale_x, out_scale_y, out_length,
               out_angle, stored_count, track_duration, status,
        input  ready
    );
    modport sink (
        input  valid, out_pos_x, out_pos_y, out_scale_x, out_scale_y, out_length,
               out_angle, stored_count, track_duration, status,
        output ready
    );
endinterface

### rtl/kts_cfg_if.sv
// ----------------------------------------------------------------------------
// kts_cfg_if
// Configuration write channel for the match tolerance register.
// ----------------------------------------------------------------------------
interface kts_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] match_tolerance;

    modport source (output valid, match_tolerance, input ready);
    modport sink (input valid, match_tolerance, output ready);
endinterface

### rtl/kts_ram.sv
// ----------------------------------------------------------------------------
// kts_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/keyframe_track_sampler_core.sv
// ----------------------------------------------------------------------------
// keyframe_track_sampler_core
// Time-sorted keyframe store with insert, remove, clear and linear sampling.
// ----------------------------------------------------------------------------
// Usage: i_item carries one operation word (insert, remove, clear, sample);
// o_result returns exactly one word for each, in order. i_cfg writes the match
// tolerance; the user must do so only while the block is idle, which the block
// does not enforce. i_cfg is ready whenever reset is released. Keyframes sit
// in one ram (one entry per keyframe, registered read data), so each pass over
// the store reads and then checks each entry touched.
// Steps per word, from accept to result loaded:
//   clear: none beyond the accept; remove: a read and check of each keyframe
//   insert: the remove pass, then a scan down from the top shifting each later
//   entry up, then the write; empty store: write only; full: remove pass only
//   sample: none when empty, one or two reads when clamped; else the clamp
//   checks, the scan up to the upper keyframe and the load, the 16-bit weight
//   divider, the angle wrap and the six shared multiply-add steps
// One word is in work at a time; i_item.ready is high only between words.
// A finished result parks in the output register, so the next word is taken
// while the receiver stalls; a second result waits until the first is taken.
// Reset empties the store (count zero) and sets the tolerance to 66; the ram
// contents are not cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
module keyframe_track_sampler_core #(
    parameter int MAX_FRAMES = kts_pkg::KTS_MAX_FRAMES
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    kts_item_if.sink     i_item,
    kts_cfg_if.sink      i_cfg,
    kts_result_if.source o_result
);
    import kts_pkg::*;

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAMES);
    localparam logic signed [35:0] PI36     = 36'sd205887;
    localparam logic signed [35:0] TWO_PI36 = 36'sd411774;

    t_state r_state, n_state;
    t_op           r_op, n_op;
    logic [23:0]   r_t, n_t;
    t_frame        r_new, n_new;
    logic [15:0]   r_tol;
    logic [CW-1:0] r_count, n_count;
    logic [23:0]   r_last, n_last;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_w, n_w;
    logic [CW-1:0] r_put, n_put;
    t_frame        r_prev, n_prev;
    t_frame        r_next, n_next;
    logic [24:0]   r_rem, n_rem;
    logic [23:0]   r_den, n_den;
    logic [15:0]   r_q, n_q;
    logic [3:0]    r_step, n_step;
    logic signed [35:0] r_rot, n_rot;
    logic          r_rot_dn, n_rot_dn;
    logic          r_rot_up, n_rot_up;
    logic signed [49:0] r_prod, n_prod;
    t_result       r_res, n_res;
    t_result       r_out;
    logic [CW-1:0] r_out_cnt;
    logic          r_ovalid;

    logic          w_accept;
    logic          w_load;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_frame        w_wdata;
    t_frame        w_rd;
    logic [23:0]   w_tdiff;
    logic          w_match;
    logic [24:0]   w_rem2;
    logic signed [32:0] w_adiff;
    logic signed [32:0] w_mdiff;
    logic signed [35:0] w_span;
    logic signed [35:0] w_sub;
    logic signed [35:0] w_add;

    assign w_accept = i_item.valid && i_item.ready;
    assign w_load   = (r_state == S_DONE) && (!r_ovalid || o_result.ready);
    assign i_item.ready = i_rst_n && (r_state == S_IDLE);
    assign i_cfg.ready  = i_rst_n;

    // keyframe store
    kts_ram #(
        .WIDTH ($bits(t_frame)),
        .DEPTH (MAX_FRAMES)
    ) u_frames (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rd)
    );

    // shared arithmetic terms
    assign w_tdiff = (w_rd.tm > r_t) ? (w_rd.tm - r_t) : (r_t - w_rd.tm);
    assign w_match = w_tdiff < {8'd0, r_tol};
    assign w_rem2  = {r_rem[23:0], 1'b0};
    assign w_adiff = 33'($signed(r_next.val[KTS_ANGLE_IDX]))
                   - 33'($signed(r_prev.val[KTS_ANGLE_IDX]));
    assign w_span  = TWO_PI36 <<< r_step;
    assign w_sub   = r_rot - w_span;
    assign w_add   = r_rot + w_span;
    assign w_mdiff = (r_step[2:0] == 3'(KTS_ANGLE_IDX)) ? r_rot[32:0]
                   : 33'($signed(r_next.val[r_step[2:0]]))
                     - 33'($signed(r_prev.val[r_step[2:0]]));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_op'(i_item.operation))
                        OP_INSERT, OP_REMOVE: n_state = (r_count == '0) ? S_DEL_END : S_DEL_RD;
                        OP_CLEAR:             n_state = S_DONE;
                        default:              n_state = (r_count == '0) ? S_DONE : S_SA_RD;
                    endcase
                end
            end
            S_DEL_RD:  n_state = S_DEL_CHK;
            S_DEL_CHK: n_state = (r_idx + 1'b1 == r_count) ? S_DEL_END : S_DEL_RD;
            S_DEL_END: begin
                if (r_op != OP_INSERT || r_count == CNT_MAX) begin
                    n_state = S_DONE;
                end else if (r_count == '0) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_state = S_INS_RD;
                end
            end
            S_INS_RD:  n_state = S_INS_CHK;
            S_INS_CHK: begin
                if (w_rd.tm > r_t && r_idx != '0) begin
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: n_state = S_DONE;
            S_SA_RD:   n_state = S_SA_CHK;
            S_SA_CHK: begin
                n_state = (r_count == CW'(1) || r_t <= w_rd.tm) ? S_DONE : S_SB_RD;
            end
            S_SB_RD:   n_state = S_SB_CHK;
            S_SB_CHK:  n_state = (r_t >= w_rd.tm) ? S_DONE : S_SC_RD;
            S_SC_RD:   n_state = S_SC_CHK;
            S_SC_CHK:  n_state = (w_rd.tm > r_t) ? S_DIV : S_SC_RD;
            S_DIV:     n_state = (r_step == 4'd15) ? S_ROT : S_DIV;
            S_ROT:     n_state = (r_step == '0) ? S_MUL : S_ROT;
            S_MUL:     n_state = S_ADD;
            S_ADD:     n_state = (r_step[2:0] == 3'(KTS_ANGLE_IDX)) ? S_DONE : S_MUL;
            S_DONE:    n_state = w_load ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and ram write control
    always_comb begin
        n_op     = r_op;
        n_t      = r_t;
        n_new    = r_new;
        n_count  = r_count;
        n_last   = r_last;
        n_idx    = r_idx;
        n_w      = r_w;
        n_put    = r_put;
        n_prev   = r_prev;
        n_next   = r_next;
        n_rem    = r_rem;
        n_den    = r_den;
        n_q      = r_q;
        n_step   = r_step;
        n_rot    = r_rot;
        n_rot_dn = r_rot_dn;
        n_rot_up = r_rot_up;
        n_prod   = r_prod;
        n_res    = r_res;
        w_we     = 1'b0;
        w_waddr  = r_w[AW-1:0];
        w_wdata  = w_rd;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op      = t_op'(i_item.operation);
                    n_t       = i_item.key_time;
                    n_new.tm  = i_item.key_time;
                    n_new.val = {i_item.angle, i_item.bone_length, i_item.scale_y,
                                 i_item.scale_x, i_item.pos_y, i_item.pos_x};
                    n_res     = '0;
                    n_idx     = '0;
                    n_w       = '0;
                    if (t_op'(i_item.operation) == OP_CLEAR) begin
                        n_count = '0;
                    end
                    if (t_op'(i_item.operation) == OP_SAMPLE && r_count == '0) begin
                        n_res.status = ST_EMPTY;
                    end
                end
            end
            // compact the store, dropping matching times
            S_DEL_CHK: begin
                if (!w_match) begin
                    w_we   = 1'b1;
                    n_w    = r_w + 1'b1;
                    n_last = w_rd.tm;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx + 1'b1 == r_count) begin
                    n_count = w_match ? r_w : r_w + 1'b1;
                end
            end
            S_DEL_END: begin
                if (r_op == OP_INSERT) begin
                    if (r_count == CNT_MAX) begin
                        n_res.status = ST_FULL;
                    end else if (r_count == '0) begin
                        n_put  = '0;
                        n_last = r_t;
                    end else begin
                        n_idx = r_count - 1'b1;
                    end
                end
            end
            // shift later keyframes up from the top
            S_INS_CHK: begin
                if (w_rd.tm > r_t) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_idx + 1'b1);
                    if (r_idx == '0) begin
                        n_put = '0;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end else begin
                    n_put = r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_count) begin
                        n_last = r_t;
                    end
                end
            end
            S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_put[AW-1:0];
                w_wdata = r_new;
                n_count = r_count + 1'b1;
            end
            // sample: clamp at the first keyframe
            S_SA_CHK: begin
                n_prev = w_rd;
                if (r_count == CW'(1) || r_t <= w_rd.tm) begin
                    n_res.val = w_rd.val;
                end else begin
                    n_idx = r_count - 1'b1;
                end
            end
            // sample: clamp at the last keyframe
            S_SB_CHK: begin
                if (r_t >= w_rd.tm) begin
                    n_res.val = w_rd.val;
                end else begin
                    n_idx = CW'(1);
                end
            end
            // scan for the bracketing pair
            S_SC_CHK: begin
                if (w_rd.tm > r_t) begin
                    n_next = w_rd;
                    n_rem  = {1'b0, r_t - r_prev.tm};
                    n_den  = w_rd.tm - r_prev.tm;
                    n_q    = '0;
                    n_step = '0;
                end else begin
                    n_prev = w_rd;
                    n_idx  = r_idx + 1'b1;
                end
            end
            // restoring divider, one weight bit per cycle
            S_DIV: begin
                if (w_rem2 >= {1'b0, r_den}) begin
                    n_rem = w_rem2 - {1'b0, r_den};
                    n_q   = {r_q[14:0], 1'b1};
                end else begin
                    n_rem = w_rem2;
                    n_q   = {r_q[14:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == 4'd15) begin
                    n_rot    = 36'(w_adiff);
                    n_rot_dn = 36'(w_adiff) > PI36;
                    n_rot_up = 36'(w_adiff) < -PI36;
                    n_step   = 4'd14;
                end
            end
            // wrap the angle step into [-pi, pi], binary multiples of two pi
            S_ROT: begin
                if (r_rot_dn && w_sub > -PI36) begin
                    n_rot = w_sub;
                end else if (r_rot_up && w_add < PI36) begin
                    n_rot = w_add;
                end
                n_step = (r_step == '0) ? '0 : r_step - 1'b1;
            end
            S_MUL: begin
                n_prod = 50'(w_mdiff * $signed({1'b0, r_q}));
            end
            S_ADD: begin
                n_res.val[r_step[2:0]] = r_prev.val[r_step[2:0]] + r_prod[47:16];
                n_step = r_step + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_tol    <= KTS_TOL_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                r_tol <= i_cfg.match_tolerance;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_t      <= n_t;
        r_new    <= n_new;
        r_last   <= n_last;
        r_idx    <= n_idx;
        r_w      <= n_w;
        r_put    <= n_put;
        r_prev   <= n_prev;
        r_next   <= n_next;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_q      <= n_q;
        r_step   <= n_step;
        r_rot    <= n_rot;
        r_rot_dn <= n_rot_dn;
        r_rot_up <= n_rot_up;
        r_prod   <= n_prod;
        r_res    <= n_res;
        if (w_load) begin
            r_out     <= '{r_res.val, ((r_count == '0) ? 24'd0 : r_last), r_res.status};
            r_out_cnt <= r_count;
        end
    end

    // result word
    assign o_result.valid          = r_ovalid;
    assign o_result.out_pos_x      = r_out.val[0];
    assign o_result.out_pos_y      = r_out.val[1];
    assign o_result.out_scale_x    = r_out.val[2];
    assign o_result.out_scale_y    = r_out.val[3];
    assign o_result.out_length     = r_out.val[4];
    assign o_result.out_angle      = r_out.val[5];
    assign o_result.stored_count   = $bits(o_result.stored_count)'(r_out_cnt);
    assign o_result.track_duration = r_out.duration;
    assign o_result.status         = r_out.status;

    // store never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("keyframe count above capacity");

    // ram writes stay inside the filled region plus one
    a_write_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> {1'b0, w_waddr} <= (AW+1)'(r_count))
        else $error("ram write beyond fill");

    // bracketing scan never leaves the stored keyframes
    a_scan_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SC_CHK |-> r_idx < r_count)
        else $error("sample scan past last keyframe");

    // a dropped insert only happens on a full store
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.status == ST_FULL) |-> r_count == CNT_MAX)
        else $error("full status on a store with room");

endmodule

### tb/keyframe_track_sampler_core_tb.sv
// ----------------------------------------------------------------------------
// keyframe_track_sampler_core_tb
// Drives insert, remove, clear and sample words into the keyframe store under
// several match tolerances and random stalls on both channels, predicts every
// result word from a behavioral copy of the sorted store and compares each
// field in order.
// ----------------------------------------------------------------------------
module keyframe_track_sampler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kts_pkg::*;

    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic [1:0]         op;
        logic [23:0]        tm;
        logic signed [31:0] val [6];
    } t_word;

    typedef struct {
        logic [31:0] val [6];
        logic [6:0]  count;
        logic [23:0] duration;
        logic [1:0]  status;
    } t_expect;

    // behavioral copy of the keyframe store and the expected word queue
    class track_scoreboard;
        logic [23:0]        key_tm  [64];
        logic signed [31:0] key_val [64][6];
        int                 count;
        logic [15:0]        tol;
        t_expect            pending [$];
        int                 errors;

        function new();
            count = 0;
            tol = KTS_TOL_RESET;
            errors = 0;
        endfunction

        function bit near(logic [23:0] a, logic [23:0] b);
            int d;
            d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
            return d < int'(tol);
        endfunction

        function void drop_near(logic [23:0] t);
            int w;
            w = 0;
            for (int r = 0; r < count; r++) begin
                if (!near(key_tm[r], t)) begin
                    key_tm[w] = key_tm[r];
                    key_val[w] = key_val[r];
                    w++;
                end
            end
            count = w;
        endfunction

        function longint floor16(longint p);
            if (p >= 0) return p / 65536;
            return -((-p + 65535) / 65536);
        endfunction

        // note an accepted word: update the store, queue the expected result
        function void note_word(t_word wd);
            t_expect e;
            int p, nx, last;
            longint w, a, d;
            for (int k = 0; k < 6; k++) e.val[k] = '0;
            e.status = ST_OK;
            case (t_op'(wd.op))
                OP_INSERT: begin
                    drop_near(wd.tm);
                    if (count >= 64) begin
                        e.status = ST_FULL;
                    end else begin
                        p = 0;
                        while (p < count && key_tm[p] <= wd.tm) p++;
                        for (int i = count; i > p; i--) begin
                            key_tm[i] = key_tm[i-1];
                            key_val[i] = key_val[i-1];
                        end
                        key_tm[p] = wd.tm;
                        for (int k = 0; k < 6; k++) key_val[p][k] = wd.val[k];
                        count++;
                    end
                end
                OP_REMOVE: drop_near(wd.tm);
                OP_CLEAR:  count = 0;
                default: begin
                    last = count - 1;
                    if (count == 0) begin
                        e.status = ST_EMPTY;
                    end else if (count == 1 || wd.tm <= key_tm[0]) begin
                        for (int k = 0; k < 6; k++) e.val[k] = key_val[0][k];
                    end else if (wd.tm >= key_tm[last]) begin
                        for (int k = 0; k < 6; k++) e.val[k] = key_val[last][k];
                    end else begin
                        nx = 1;
                        while (nx < last && key_tm[nx] <= wd.tm) nx++;
                        w = (longint'(wd.tm - key_tm[nx-1]) << 16) /
                            longint'(key_tm[nx] - key_tm[nx-1]);
                        for (int k = 0; k < 6; k++) begin
                            a = key_val[nx-1][k];
                            d = longint'(key_val[nx][k]) - a;
                            if (k == KTS_ANGLE_IDX) begin
                                while (d > KTS_FIX_PI) d -= KTS_FIX_TWO_PI;
                                while (d < -KTS_FIX_PI) d += KTS_FIX_TWO_PI;
                            end
                            e.val[k] = 32'(a + floor16(d * w));
                        end
                    end
                end
            endcase
            e.count = 7'(count);
            e.duration = count ? key_tm[count-1] : '0;
            pending.push_back(e);
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %h, got %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // check one result word against the oldest expectation
        function void check_result(logic [31:0] v [6], logic [6:0] cnt,
                                   logic [23:0] dur, logic [1:0] st);
            t_expect e;
            if (pending.size() == 0) begin
                $error("result word with no expectation pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("out_pos_x", e.val[0], v[0]);
            cmp("out_pos_y", e.val[1], v[1]);
            cmp("out_scale_x", e.val[2], v[2]);
            cmp("out_scale_y", e.val[3], v[3]);
            cmp("out_length", e.val[4], v[4]);
            cmp("out_angle", e.val[5], v[5]);
            cmp("stored_count", 32'(e.count), 32'(cnt));
            cmp("track_duration", 32'(e.duration), 32'(dur));
            cmp("status", 32'(e.status), 32'(st));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kts_item_if   item_ch ();
    kts_cfg_if    cfg_ch ();
    kts_result_if res_ch ();

    keyframe_track_sampler_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .o_result (res_ch.source)
    );

    track_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    int  idle_cycles = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        item_ch.valid = 1'b0;
        item_ch.operation = '0;
        item_ch.key_time = '0;
        item_ch.pos_x = '0;
        item_ch.pos_y = '0;
        item_ch.scale_x = '0;
        item_ch.scale_y = '0;
        item_ch.bone_length = '0;
        item_ch.angle = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.match_tolerance = '0;
        res_ch.ready = 1'b0;
    end

    // result side: random stall, check on each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_result('{res_ch.out_pos_x, res_ch.out_pos_y, res_ch.out_scale_x,
                              res_ch.out_scale_y, res_ch.out_length, res_ch.out_angle},
                            res_ch.stored_count, res_ch.track_duration, res_ch.status);
        end
        res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("keyframe_track_sampler_core_tb NOT OK");
            $finish;
        end
    end

    // valid stays up between back-to-back words and drops only while idling
    task automatic send_word(t_word wd);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.operation <= wd.op;
        item_ch.key_time <= wd.tm;
        item_ch.pos_x <= wd.val[0];
        item_ch.pos_y <= wd.val[1];
        item_ch.scale_x <= wd.val[2];
        item_ch.scale_y <= wd.val[3];
        item_ch.bone_length <= wd.val[4];
        item_ch.angle <= wd.val[5];
        do @(posedge i_clk); while (!item_ch.ready);
        sb.note_word(wd);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_tol(logic [15:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.match_tolerance <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.tol = v;
    endtask

    function automatic logic signed [31:0] rnd_val();
        case ($urandom_range(4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(800000))) - 400000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic t_word mk(logic [1:0] op, logic [23:0] tm);
        t_word wd;
        wd.op = op;
        wd.tm = tm;
        for (int k = 0; k < 6; k++) wd.val[k] = rnd_val();
        return wd;
    endfunction

    // random word: mostly inserts and samples over a time window
    function automatic t_word rnd_word(int span);
        int r;
        logic [23:0] tm;
        r = $urandom_range(99);
        tm = (span >= 24'hffffff) ? 24'($urandom()) : 24'($urandom_range(span));
        if (r < 45) return mk(OP_INSERT, tm);
        if (r < 90) return mk(OP_SAMPLE, tm);
        if (r < 98) return mk(OP_REMOVE, tm);
        return mk(OP_CLEAR, tm);
    endfunction

    task automatic random_phase(int n, int span);
        for (int i = 0; i < n; i++) send_word(rnd_word(span));
    endtask

    initial begin
        t_word wd;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, single keyframe, clamps, wrap
        send_word(mk(OP_SAMPLE, 24'd0));
        send_word(mk(OP_REMOVE, 24'd5));
        send_word(mk(OP_CLEAR, 24'd0));
        send_word(mk(OP_INSERT, 24'h000100));
        send_word(mk(OP_SAMPLE, 24'hffffff));
        send_word(mk(OP_SAMPLE, 24'd0));
        wd = mk(OP_INSERT, 24'hffffff);
        wd.val = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                   32'sh0, 32'sh7fffffff};
        send_word(wd);
        wd = mk(OP_INSERT, 24'h800000);
        wd.val = '{32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh7fffffff,
                   32'shffffffff, 32'sh80000000};
        send_word(wd);
        send_word(mk(OP_SAMPLE, 24'h400000));
        send_word(mk(OP_SAMPLE, 24'hc00000));
        send_word(mk(OP_SAMPLE, 24'hfffffe));
        send_word(mk(OP_INSERT, 24'h800020));
        send_word(mk(OP_SAMPLE, 24'h800010));
        send_word(mk(OP_REMOVE, 24'h800000));
        send_word(mk(OP_SAMPLE, 24'h800000));
        send_word(mk(OP_CLEAR, 24'd0));
        send_word(mk(OP_SAMPLE, 24'h123456));
        drain();

        // fill to capacity, then insert into the full store
        write_tol(16'd0);
        for (int i = 0; i < 64; i++) send_word(mk(OP_INSERT, 24'(i * 1000)));
        send_word(mk(OP_INSERT, 24'd500));
        send_word(mk(OP_INSERT, 24'd2000));
        send_word(mk(OP_SAMPLE, 24'd31500));
        send_word(mk(OP_INSERT, 24'd70000));
        drain();
        write_tol(16'hffff);
        send_word(mk(OP_INSERT, 24'd3000));
        send_word(mk(OP_INSERT, 24'd3000));
        drain();

        // random phases with receiver then sender idling
        write_tol(16'd66);
        send_idle_pct = 6;
        recv_idle_pct = 53;
        random_phase(350, 200000);
        drain();
        write_tol(16'd0);
        send_idle_pct = 53;
        recv_idle_pct = 6;
        random_phase(30, 15);
        random_phase(320, 24'hffffff);
        drain();

        // long receiver hold while the sender keeps offering
        write_tol(16'd2000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (3000) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            random_phase(40, 100000);
        join
        drain();
        write_tol(16'd1);
        random_phase(350, 60000);
        drain();
        write_tol(16'hffff);
        random_phase(300, 24'hffffff);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("keyframe_track_sampler_core_tb OK");
        else
            $display("keyframe_track_sampler_core_tb NOT OK");
        $finish;
    end
endmodule
